FILE: src/bfsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsw_pkg: box filter shared definitions
// Register indexes, field widths, default limits and reset values.
// ----------------------------------------------------------------------------
package bfsw_pkg;

  localparam int unsigned DEF_MAX_KERNEL = 16;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned HSUM_W  = 12;
  localparam int unsigned CSUM_W  = 16;
  localparam int unsigned RECIP_W = 17;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned IDX_W   = 2;

  localparam int unsigned KSIZE_RAW_W  = 5;
  localparam int unsigned WIDTH_RAW_W  = 11;
  localparam int unsigned HEIGHT_RAW_W = 13;

  localparam int unsigned KSIZE_RST  = 3;
  localparam int unsigned WIDTH_RST  = 1024;
  localparam int unsigned HEIGHT_RST = 1024;
  localparam int unsigned RECIP_RST  = 7282;
  localparam int unsigned RECIP_MAX  = 65536;

  typedef enum logic [IDX_W-1:0] {
    CFG_KERNEL = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_RECIP  = 2'd3
  } cfg_idx_e;

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    int unsigned r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

FILE: src/box_filter_sliding_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_sliding_window: streaming K-by-K mean filter
// Each result passes three register stages (stage B, stage C, output) between the
// edge that accepts its pixel and m_axis.
// Throughput: one pixel per cycle while m_axis is not stalled; the column-sum and
// line-store memories are read on accept and written from stage B, with a last-write bypass.
// Reset: counters, running sum and configuration return to defaults; the
// memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module box_filter_sliding_window
  import bfsw_pkg::*;
#(
  parameter int unsigned MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [PIX_W-1:0]   m_axis_tdata,   // [7:0] out_pixel
  output logic               m_axis_tlast,   // end_of_row
  output logic               m_axis_tuser    // [0] end_of_frame
);

  localparam int unsigned KW  = $clog2(MAX_KERNEL + 1);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW  = $clog2(MAX_WIDTH + MAX_KERNEL);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + MAX_KERNEL);
  localparam int unsigned SW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned LD  = MAX_KERNEL * MAX_WIDTH;
  localparam int unsigned LAW = (LD > 1) ? $clog2(LD) : 1;
  localparam int unsigned PW  = CSUM_W + RECIP_W;

  localparam int unsigned K_RST = clamp_u(KSIZE_RST, 1, MAX_KERNEL);
  localparam int unsigned W_RST = clamp_u(WIDTH_RST, 1, MAX_WIDTH);
  localparam int unsigned H_RST = clamp_u(HEIGHT_RST, 1, MAX_HEIGHT);

  // configuration, stored clamped
  logic [KW-1:0]      k_q;
  logic [WW-1:0]      w_q;
  logic [HW-1:0]      h_q;
  logic [RECIP_W-1:0] rc_q;

  // frame position
  logic [CW-1:0]     c_q, c_d;
  logic [RW-1:0]     r_q, r_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [SW-1:0]     rslot_q, rslot_d;
  logic [HSUM_W-1:0] rsum_q;
  logic [PIX_W-1:0]  win_q [MAX_KERNEL];

  // memories
  logic [CSUM_W-1:0] col_mem  [MAX_WIDTH];
  logic [HSUM_W-1:0] line_mem [LD];
  logic [CSUM_W-1:0] col_rd_q;
  logic [HSUM_W-1:0] line_rd_q;

  // stage B
  logic              b_v_q;
  logic [HSUM_W-1:0] b_hs_q;
  logic [XW-1:0]     b_x_q;
  logic [LAW-1:0]    b_la_q;
  logic              b_rz_q, b_rlt_q, b_oen_q, b_eor_q, b_eof_q;

  // last-write bypass
  logic              fc_v_q, fl_v_q;
  logic [XW-1:0]     fc_a_q;
  logic [CSUM_W-1:0] fc_d_q;
  logic [LAW-1:0]    fl_a_q;
  logic [HSUM_W-1:0] fl_d_q;

  // stage C
  logic              c_v_q;
  logic [CSUM_W-1:0] c_cs_q;
  logic              c_eor_q, c_eof_q;

  // output
  logic              o_v_q;
  logic [PIX_W-1:0]  o_pix_q;
  logic              o_eor_q, o_eof_q;

  logic              cfg_hit;
  logic              acc, emit, b_go, c_rdy, o_rdy;
  logic [CW-1:0]     k_c, c_last, x_full;
  logic [RW-1:0]     k_r, r_last;
  logic [XW-1:0]     x;
  logic [LAW-1:0]    la;
  logic [PIX_W-1:0]  leaving;
  logic [HSUM_W-1:0] hs;
  logic [CSUM_W-1:0] col_old, cs;
  logic [HSUM_W-1:0] line_old;
  logic [PW-1:0]     prod;
  logic [PW:0]       rnd;
  logic [PW-16:0]    mean;

  // ---------------- configuration ----------------
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KERNEL, CFG_WIDTH, CFG_HEIGHT, CFG_RECIP: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= KW'(K_RST);
      w_q  <= WW'(W_RST);
      h_q  <= HW'(H_RST);
      rc_q <= RECIP_W'(RECIP_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KERNEL: k_q <= KW'(clamp_u(32'(cfg_data_i[KSIZE_RAW_W-1:0]), 1, MAX_KERNEL));
        CFG_WIDTH:  w_q <= WW'(clamp_u(32'(cfg_data_i[WIDTH_RAW_W-1:0]), 1, MAX_WIDTH));
        CFG_HEIGHT: h_q <= HW'(clamp_u(32'(cfg_data_i[HEIGHT_RAW_W-1:0]), 1, MAX_HEIGHT));
        CFG_RECIP:  rc_q <= RECIP_W'(clamp_u(32'(cfg_data_i), 0, RECIP_MAX));
        default: ;
      endcase
    end
  end

  // ---------------- stage A: accept, horizontal sum, memory read ----------------
  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    k_c     = CW'(k_q);
    k_r     = RW'(k_q);
    c_last  = CW'(w_q) + k_c - CW'(2);
    r_last  = RW'(h_q) + k_r - RW'(2);
    leaving = (c_q >= k_c) ? win_q[slot_q] : '0;
    hs      = ((c_q == '0) ? '0 : rsum_q) + HSUM_W'(s_axis_tdata) - HSUM_W'(leaving);
    emit    = c_q >= (k_c - CW'(1));
    x_full  = c_q - (k_c - CW'(1));
    x       = x_full[XW-1:0];
    la      = LAW'(rslot_q) * LAW'(MAX_WIDTH) + LAW'(x);

    c_d     = c_q;
    r_d     = r_q;
    slot_d  = slot_q;
    rslot_d = rslot_q;
    if (c_q == c_last) begin
      c_d    = '0;
      slot_d = '0;
      if (r_q == r_last) begin
        r_d     = '0;
        rslot_d = '0;
      end else begin
        r_d     = r_q + RW'(1);
        rslot_d = (RW'(rslot_q) == k_r - RW'(1)) ? '0 : rslot_q + SW'(1);
      end
    end else begin
      c_d    = c_q + CW'(1);
      slot_d = (CW'(slot_q) == k_c - CW'(1)) ? '0 : slot_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q     <= '0;
      r_q     <= '0;
      slot_q  <= '0;
      rslot_q <= '0;
      rsum_q  <= '0;
    end else if (cfg_hit) begin
      c_q     <= '0;
      r_q     <= '0;
      slot_q  <= '0;
      rslot_q <= '0;
      rsum_q  <= '0;
    end else if (acc) begin
      c_q     <= c_d;
      r_q     <= r_d;
      slot_q  <= slot_d;
      rslot_q <= rslot_d;
      rsum_q  <= hs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      win_q[slot_q] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      col_mem[b_x_q] <= cs;
    end
    if (acc && emit) begin
      col_rd_q <= col_mem[x];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      line_mem[b_la_q] <= b_hs_q;
    end
    if (acc && emit) begin
      line_rd_q <= line_mem[la];
    end
  end

  // ---------------- stage B: column sum update ----------------
  assign c_rdy         = !c_v_q || o_rdy;
  assign b_go          = b_v_q && (!b_oen_q || c_rdy);
  assign s_axis_tready = !b_v_q || b_go;

  always_comb begin
    col_old  = (fc_v_q && fc_a_q == b_x_q) ? fc_d_q : col_rd_q;
    line_old = (fl_v_q && fl_a_q == b_la_q) ? fl_d_q : line_rd_q;
    if (b_rz_q) begin
      cs = CSUM_W'(b_hs_q);
    end else if (b_rlt_q) begin
      cs = col_old + CSUM_W'(b_hs_q);
    end else begin
      cs = col_old + CSUM_W'(b_hs_q) - CSUM_W'(line_old);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q  <= 1'b0;
      fc_v_q <= 1'b0;
      fl_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        b_v_q <= acc && emit;
      end
      if (b_go) begin
        fc_v_q <= 1'b1;
        fl_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && emit) begin
      b_hs_q  <= hs;
      b_x_q   <= x;
      b_la_q  <= la;
      b_rz_q  <= r_q == '0;
      b_rlt_q <= r_q < k_r;
      b_oen_q <= r_q >= (k_r - RW'(1));
      b_eor_q <= WW'(x) == (w_q - WW'(1));
      b_eof_q <= (WW'(x) == (w_q - WW'(1))) && (r_q == r_last);
    end
    if (b_go) begin
      fc_a_q <= b_x_q;
      fc_d_q <= cs;
      fl_a_q <= b_la_q;
      fl_d_q <= b_hs_q;
    end
  end

  // ---------------- stage C: scale, round, saturate ----------------
  assign o_rdy = !o_v_q || m_axis_tready;

  always_comb begin
    prod = PW'(c_cs_q) * PW'(rc_q);
    rnd  = (PW + 1)'(prod) + (PW + 1)'(32768);
    mean = rnd[PW:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (c_rdy) begin
        c_v_q <= b_go && b_oen_q;
      end
      if (o_rdy) begin
        o_v_q <= c_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_rdy) begin
      c_cs_q  <= cs;
      c_eor_q <= b_eor_q;
      c_eof_q <= b_eof_q;
    end
    if (o_rdy && c_v_q) begin
      o_pix_q <= (mean > (PW - 15)'(255)) ? 8'hFF : mean[PIX_W-1:0];
      o_eor_q <= c_eor_q;
      o_eof_q <= c_eof_q;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = o_pix_q;
  assign m_axis_tlast  = o_eor_q;
  assign m_axis_tuser  = o_eof_q;

endmodule

FILE: tb/box_filter_sliding_window_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_sliding_window_test: self-checking bench for the box filter
// Streams padded frames into the filter under a run of register settings,
// predicts every mean, end-of-row and end-of-frame flag from its own model
// of the running sums, and checks each output request against the oldest
// pending prediction.
// ----------------------------------------------------------------------------
module box_filter_sliding_window_test;
  import bfsw_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RAND_PIXELS = 400;
  localparam int unsigned MAX_PRINTS  = 100;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             eor;
    logic             eof;
  } mean_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata = '0;   // [7:0] pixel
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [PIX_W-1:0] m_axis_tdata;        // [7:0] out_pixel
  logic             m_axis_tlast;        // end_of_row
  logic             m_axis_tuser;        // [0] end_of_frame

  box_filter_sliding_window uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // filter model state
  logic [KSIZE_RAW_W-1:0]  cfg_kernel;
  logic [WIDTH_RAW_W-1:0]  cfg_width;
  logic [HEIGHT_RAW_W-1:0] cfg_height;
  logic [RECIP_W-1:0]      cfg_recip;
  logic [PIX_W-1:0]  row_pix [0:DEF_MAX_KERNEL-1];
  logic [HSUM_W-1:0] row_sum;
  logic [HSUM_W-1:0] hsum_mem [0:DEF_MAX_KERNEL*DEF_MAX_WIDTH-1];
  logic [CSUM_W-1:0] col_sum [0:DEF_MAX_WIDTH-1];
  int unsigned       col_cnt;
  int unsigned       row_cnt;

  logic [PIX_W-1:0] pixel_q[$];
  mean_t            mean_q[$];
  mean_t            want_mean;

  int unsigned pix_pushed = 0;
  int unsigned pix_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned errors = 0;
  int unsigned settings_used = 0;
  int unsigned rand_pix = 0;
  int unsigned idle_cnt = 0;
  logic        in_taken = 1'b0;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned gap_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned hold_cnt = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          no_idle = 1'b0;

  function automatic int unsigned limit_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_frame();
    col_cnt = 0;
    row_cnt = 0;
    row_sum = '0;
    for (int i = 0; i < DEF_MAX_KERNEL; i++) row_pix[i] = '0;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] mismatch %0d, %s: got %0d, expected %0d", $time, errors, what, got,
               want);
  endtask

  task automatic predict_pixel(input logic [PIX_W-1:0] px);
    int unsigned k, w, h, rc, pw, ph, c, r, slot, x, y, line;
    logic [PIX_W-1:0]  leaving;
    logic [HSUM_W-1:0] hs;
    logic [CSUM_W-1:0] cs;
    longint unsigned   prod;
    mean_t             res;
    k  = limit_to(cfg_kernel, 1, DEF_MAX_KERNEL);
    w  = limit_to(cfg_width, 1, DEF_MAX_WIDTH);
    h  = limit_to(cfg_height, 1, DEF_MAX_HEIGHT);
    rc = limit_to(cfg_recip, 0, RECIP_MAX);
    pw = w + k - 1;
    ph = h + k - 1;
    c = col_cnt;
    r = row_cnt;
    slot = c % k;
    leaving = (c >= k) ? row_pix[slot] : '0;
    if (c >= pw) c = 0;
    if (r >= ph) r = 0;
    row_sum = ((c == 0) ? '0 : row_sum) + px - leaving;
    row_pix[slot] = px;
    if (c + 1 >= k) begin
      x = c + 1 - k;
      line = (r % k) * DEF_MAX_WIDTH + x;
      hs = row_sum;
      if (r == 0) begin
        cs = hs;
      end else if (r < k) begin
        cs = col_sum[x] + hs;
      end else begin
        cs = col_sum[x] + hs - hsum_mem[line];
      end
      col_sum[x] = cs;
      hsum_mem[line] = hs;
      if (r + 1 >= k) begin
        y = r + 1 - k;
        prod = cs;
        prod = ((prod * rc) + 64'd32768) >> 16;
        res.pix = (prod > 255) ? 8'd255 : prod[7:0];
        res.eor = (x == w - 1);
        res.eof = (x == w - 1) && (y == h - 1);
        mean_q.push_back(res);
      end
    end
    c++;
    if (c >= pw) begin
      c = 0;
      r++;
      if (r >= ph) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  // pixel source
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        s_axis_tdata  <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < gap_pct) gap_cnt = $urandom_range(1, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output sink, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < stall_pct) stall_cnt = $urandom_range(1, 10);
    end
  end

  // monitor: predict on input request, check on output request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pixel(s_axis_tdata);
        pix_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (mean_q.size() == 0) begin
          report_mismatch("output with no mean pending", m_axis_tdata, 0);
        end else begin
          want_mean = mean_q.pop_front();
          if (m_axis_tdata !== want_mean.pix)
            report_mismatch("out_pixel", m_axis_tdata, want_mean.pix);
          if (m_axis_tlast !== want_mean.eor)
            report_mismatch("end_of_row", m_axis_tlast, want_mean.eor);
          if (m_axis_tuser !== want_mean.eof)
            report_mismatch("end_of_frame", m_axis_tuser, want_mean.eof);
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("watchdog: no request for %0d cycles, %0d means pending", idle_cnt,
               mean_q.size());
      $display("** box_filter_sliding_window: FAILED **");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_KERNEL: cfg_kernel = val[KSIZE_RAW_W-1:0];
      CFG_WIDTH:  cfg_width  = val[WIDTH_RAW_W-1:0];
      CFG_HEIGHT: cfg_height = val[HEIGHT_RAW_W-1:0];
      CFG_RECIP:  cfg_recip  = val[RECIP_W-1:0];
      default: ;
    endcase
    restart_frame();
    settings_used++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned k, input int unsigned w, input int unsigned h,
                              input int unsigned rc);
    cfg_write(CFG_KERNEL, CFG_W'(k));
    cfg_write(CFG_WIDTH, CFG_W'(w));
    cfg_write(CFG_HEIGHT, CFG_W'(h));
    cfg_write(CFG_RECIP, CFG_W'(rc));
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] v);
    pixel_q.push_back(v);
    pix_pushed++;
  endtask

  task automatic push_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_pixel(PIX_W'($urandom_range(0, 255)));
  endtask

  task automatic wait_drain();
    do @(negedge clk_i); while (pix_accepted != pix_pushed || mean_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    int unsigned k, w, h, pw, ph, n, pick;
    logic [CFG_W-1:0] val;
    cfg_idx_e order[$];

    cfg_kernel = KSIZE_RST;
    cfg_width  = WIDTH_RST;
    cfg_height = HEIGHT_RST;
    cfg_recip  = RECIP_RST;
    for (int i = 0; i < DEF_MAX_KERNEL * DEF_MAX_WIDTH; i++) hsum_mem[i] = '0;
    for (int i = 0; i < DEF_MAX_WIDTH; i++) col_sum[i] = '0;
    restart_frame();
    gap_pct = 20;
    stall_pct = 20;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: warm-up rows give no output
    push_random(20);
    wait_drain();

    // reset kernel and reciprocal on a small frame
    cfg_write(CFG_WIDTH, CFG_W'(4));
    cfg_write(CFG_HEIGHT, CFG_W'(2));
    push_random(6 * 4);
    wait_drain();

    // 1x1 window, unit reciprocal: output equals input
    set_geometry(1, 4, 2, RECIP_MAX);
    push_pixel(8'd0);
    push_pixel(8'd255);
    push_pixel(8'd1);
    push_pixel(8'd128);
    push_pixel(8'd254);
    push_pixel(8'd127);
    push_pixel(8'd85);
    push_pixel(8'd170);
    wait_drain();

    // zero kernel, zero sizes, zero reciprocal
    set_geometry(0, 0, 0, 0);
    push_pixel(8'd255);
    push_pixel(8'd0);
    wait_drain();

    // saturation at 255
    set_geometry(2, 2, 2, RECIP_MAX);
    for (int i = 0; i < 9; i++) push_pixel(8'd255);
    push_random(3);
    wait_drain();

    // restart in the middle of a frame
    set_geometry(3, 3, 3, 7282);
    push_random(13);
    wait_drain();
    cfg_write(CFG_RECIP, CFG_W'(7282));
    push_random(25 + 5);
    wait_drain();

    // oversize kernel and reciprocal
    set_geometry(31, 1, 1, 17'h1FFFF);
    for (int i = 0; i < 256; i++) push_pixel(8'd255);
    push_random(16);
    wait_drain();

    // long output hold-off while pixels keep coming
    set_geometry(1, 8, 16, RECIP_MAX);
    hold_req = 1'b1;
    push_random(8 * 16);
    wait_drain();

    // random geometries, mostly whole frames
    while (rand_pix < RAND_PIXELS) begin
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      order = {CFG_WIDTH, CFG_HEIGHT};
      if ($urandom_range(0, 3) != 0) order.push_back(CFG_KERNEL);
      if ($urandom_range(0, 3) != 0) order.push_back(CFG_RECIP);
      while (order.size() > 0) begin
        pick = $urandom_range(0, order.size() - 1);
        case (order[pick])
          CFG_KERNEL: begin
            case ($urandom_range(0, 9))
              0: k = 0;
              1: k = $urandom_range(17, 31);
              default: k = $urandom_range(1, 16);
            endcase
            val = CFG_W'($urandom & 17'h1FFE0) | CFG_W'(k);
          end
          CFG_WIDTH: begin
            w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
            val = CFG_W'($urandom & 17'h1F800) | CFG_W'(w);
          end
          CFG_HEIGHT: begin
            h = $urandom_range(0, 6);
            val = CFG_W'($urandom & 17'h1E000) | CFG_W'(h);
          end
          default: begin
            k = limit_to(cfg_kernel, 1, DEF_MAX_KERNEL);
            if ($urandom_range(0, 1) == 0) val = CFG_W'((RECIP_MAX + k * k / 2) / (k * k));
            else val = CFG_W'($urandom_range(0, 17'h1FFFF));
          end
        endcase
        cfg_write(order[pick], val);
        order.delete(pick);
      end
      k  = limit_to(cfg_kernel, 1, DEF_MAX_KERNEL);
      pw = limit_to(cfg_width, 1, DEF_MAX_WIDTH) + k - 1;
      ph = limit_to(cfg_height, 1, DEF_MAX_HEIGHT) + k - 1;
      n  = $urandom_range(0, 2) * pw * ph + $urandom_range(0, 2 * pw);
      if (n == 0) n = pw * ph;
      push_random(n);
      rand_pix += n;
      wait_drain();
    end

    // closing stretch at full rate
    no_idle = 1'b1;
    set_geometry(4, 8, 4, (RECIP_MAX + 8) / 16);
    push_random(11 * 7);
    wait_drain();

    $display("run covered %0d pixels and %0d checked means over %0d register writes,",
             pix_accepted, results_checked, settings_used);
    $display("including clamped kernel, size and reciprocal values and a long output hold-off");
    if (errors == 0) begin
      $display("** box_filter_sliding_window: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** box_filter_sliding_window: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bfsw_pkg.sv
src/box_filter_sliding_window.sv
tb/box_filter_sliding_window_test.sv
